// ===== rtl/core/slrg_pkg.sv =====
// Shared types, codes and constants of the sprite list row generator.
`default_nettype none
package slrg_pkg;

	// Parameter defaults and fixed geometry.
	localparam int unsigned TILE_COUNT_DEF = 4096;
	localparam int          SCREEN_WIDTH   = 256;
	localparam logic [3:0]  ROW_LAST       = 4'd15;

	// Stream word widths.
	localparam int unsigned S_DATA_W   = 136;
	localparam int unsigned M_DATA_W   = 104;
	localparam int unsigned APB_ADDR_W = 4;

	// Input command codes carried on s_tuser.
	localparam logic [1:0] CMD_FRAME  = 2'd0;
	localparam logic [1:0] CMD_SPRITE = 2'd1;
	localparam logic [1:0] CMD_LOAD   = 2'd2;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_WINDOW_TOP    = 2'd0;
	localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd1;
	localparam logic [1:0] REG_CLEAR_PEN     = 2'd2;

	localparam logic [8:0] WINDOW_TOP_RST    = 9'd16;
	localparam logic [8:0] WINDOW_BOTTOM_RST = 9'd239;
	localparam logic [3:0] CLEAR_PEN_RST     = 4'd0;

	typedef struct packed {
		logic [8:0] window_top;
		logic [8:0] window_bottom;
		logic [3:0] clear_pen;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clear_run;
		logic       load_wr;
		logic       place;
		logic       eval;
		logic       row_rd;
		logic       out_load;
		logic [3:0] row;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic        drawn;
		logic [15:0] row_vis;
		logic        out_free;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/slrg_cfg_regs.sv =====
// APB configuration registers: window top, window bottom and clear pen.
`default_nettype none
module slrg_cfg_regs import slrg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output cfg_t                       cfg
);

	logic [8:0] window_top_q;
	logic [8:0] window_bottom_q;
	logic [3:0] clear_pen_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_top_q    <= WINDOW_TOP_RST;
			window_bottom_q <= WINDOW_BOTTOM_RST;
			clear_pen_q     <= CLEAR_PEN_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_WINDOW_TOP:    window_top_q    <= pwdata[8:0];
				REG_WINDOW_BOTTOM: window_bottom_q <= pwdata[8:0];
				REG_CLEAR_PEN:     clear_pen_q     <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WINDOW_TOP:    prdata = {23'd0, window_top_q};
			REG_WINDOW_BOTTOM: prdata = {23'd0, window_bottom_q};
			REG_CLEAR_PEN:     prdata = {28'd0, clear_pen_q};
			default:           prdata = 32'd0;
		endcase
	end

	assign cfg.window_top    = window_top_q;
	assign cfg.window_bottom = window_bottom_q;
	assign cfg.clear_pen     = clear_pen_q;

endmodule
`default_nettype wire

// ===== rtl/core/slrg_datapath.sv =====
// Datapath: running position, sprite latch, tile row memory and output register.
`default_nettype none
module slrg_datapath import slrg_pkg::*; #(
	parameter int unsigned TILE_COUNT = TILE_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [S_DATA_W-1:0] s_tdata,
	input  wire cfg_t                cfg,
	input  wire dp_cmd_t             cmd,
	output dp_status_t               status,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [M_DATA_W-1:0] m_tdata,
	output logic                     m_tlast
);

	localparam int unsigned DEPTH = TILE_COUNT * 16;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [15:0] colour_word;
	logic [7:0]  x_byte;
	logic [7:0]  y_byte;
	logic [7:0]  code_low;
	logic [15:0] attr_word;
	logic [15:0] load_index;
	logic [63:0] load_pixels;

	assign colour_word = s_tdata[15:0];
	assign x_byte      = s_tdata[23:16];
	assign y_byte      = s_tdata[31:24];
	assign code_low    = s_tdata[39:32];
	assign attr_word   = s_tdata[55:40];
	assign load_index  = s_tdata[71:56];
	assign load_pixels = s_tdata[135:72];

	// Sign the byte, place it absolutely or against the running value,
	// then fold anything above 511 back to nine bits.
	function automatic logic [17:0] place_pos(logic [17:0] run, logic [7:0] raw,
			logic neg, logic rel);
		logic [17:0] s;
		logic [17:0] v;
		s = {{10{neg}}, raw};
		v = rel ? run + s : s;
		if ($signed(v) > 18'sd511)
			v = {9'd0, v[8:0]};
		return v;
	endfunction

	logic [17:0] run_x_q;
	logic [17:0] run_y_q;
	logic [11:0] tile_q;
	logic [3:0]  bank_q;
	logic        flipx_q;
	logic        flipy_q;
	logic [15:0] row_vis_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_x_q <= 18'd0;
			run_y_q <= 18'd0;
		end else if (cmd.clear_run) begin
			run_x_q <= 18'd0;
			run_y_q <= 18'd0;
		end else if (cmd.place) begin
			run_x_q <= place_pos(run_x_q, x_byte, colour_word[0], colour_word[2]);
			run_y_q <= place_pos(run_y_q, y_byte, colour_word[1], colour_word[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.place) begin
			tile_q  <= {attr_word[3:0], code_low};
			bank_q  <= colour_word[7:4];
			flipx_q <= attr_word[6];
			flipy_q <= attr_word[7];
		end
	end

	// Visibility of the sprite and of each of its sixteen rows.
	logic        tile_ok;
	logic [15:0] row_vis;

	assign tile_ok = {1'b0, tile_q} < 13'(TILE_COUNT);

	assign status.drawn = ($signed(run_x_q) > -18'sd16) && ($signed(run_x_q) < 18'sd256)
		&& ($signed(run_y_q) > 18'sd0) && ($signed(run_y_q) < 18'sd240) && tile_ok;

	always_comb begin
		logic [8:0] py_v;
		for (int r = 0; r < 16; r++) begin
			py_v = run_y_q[8:0] + (flipy_q ? 9'(15 - r) : 9'(r));
			row_vis[r] = (py_v >= cfg.window_top) && (py_v <= cfg.window_bottom);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_vis_q <= 16'd0;
		else if (cmd.eval)
			row_vis_q <= row_vis;
	end

	assign status.row_vis = row_vis_q;

	// Tile row store.
	logic [63:0] mem [DEPTH];
	logic [63:0] rd_data_q;
	logic        load_in_range;

	assign load_in_range = {1'b0, load_index} < 17'(DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_in_range)
			mem[load_index[AW-1:0]] <= load_pixels;
		if (cmd.row_rd)
			rd_data_q <= mem[AW'({tile_q, cmd.row})];
	end

	// Result formation for the row held in cmd.row.
	logic [8:0]  py_out;
	logic [8:0]  screen_row;
	logic [63:0] pix;
	logic [15:0] mask;
	logic        last;
	logic [15:0] vis_above;

	assign py_out     = run_y_q[8:0] + {5'd0, (flipy_q ? ROW_LAST - cmd.row : cmd.row)};
	assign screen_row = py_out - cfg.window_top;
	assign vis_above  = row_vis_q >> cmd.row;
	assign last       = (vis_above[15:1] == 15'd0);

	always_comb begin
		logic [3:0]  nib;
		logic [10:0] px;
		for (int k = 0; k < 16; k++) begin
			nib = flipx_q ? rd_data_q[4*(15-k) +: 4] : rd_data_q[4*k +: 4];
			pix[4*k +: 4] = nib;
			px = run_x_q[10:0] + 11'(k);
			mask[k] = (nib != cfg.clear_pen) && !px[10] && (px < 11'(SCREEN_WIDTH));
		end
	end

	// Output register; a new word loads while the old one is taken.
	logic        out_valid_q;
	logic [8:0]  out_row_q;
	logic [8:0]  out_x_q;
	logic [63:0] out_pix_q;
	logic [15:0] out_mask_q;
	logic [3:0]  out_bank_q;
	logic        out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_row_q  <= screen_row;
			out_x_q    <= run_x_q[8:0];
			out_pix_q  <= pix;
			out_mask_q <= mask;
			out_bank_q <= bank_q;
			out_last_q <= last;
		end
	end

	assign status.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'd0, out_bank_q, out_mask_q, out_pix_q, out_x_q, out_row_q};
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/core/slrg_ctrl.sv =====
// Controller: accepts words, evaluates sprites and sequences the sixteen tile rows.
`default_nettype none
module slrg_ctrl import slrg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [1:0] s_tuser,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_FETCH
	} state_t;

	state_t     state_q;
	logic [3:0] row_q;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd     = '0;
		cmd.row = row_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (s_tuser)
						CMD_FRAME:  cmd.clear_run = 1'b1;
						CMD_SPRITE: cmd.place     = 1'b1;
						CMD_LOAD:   cmd.load_wr   = 1'b1;
						default: ;
					endcase
				end
			end
			ST_EVAL:  cmd.eval     = 1'b1;
			ST_SCAN:  cmd.row_rd   = status.row_vis[row_q];
			ST_FETCH: cmd.out_load = status.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= 4'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == CMD_SPRITE)
						state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					row_q   <= 4'd0;
					state_q <= status.drawn ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					// Rows outside the window are stepped over without a read.
					if (status.row_vis[row_q])
						state_q <= ST_FETCH;
					else if (row_q == ROW_LAST)
						state_q <= ST_IDLE;
					else
						row_q <= row_q + 4'd1;
				end
				ST_FETCH: begin
					if (status.out_free) begin
						if (row_q == ROW_LAST) begin
							state_q <= ST_IDLE;
						end else begin
							row_q   <= row_q + 4'd1;
							state_q <= ST_SCAN;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result word loaded while the output register is occupied");

	a_fetch_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> ($past(cmd.row_rd) || $past(state_q == ST_FETCH)))
		else $error("fetch state entered without a tile row read");

	a_eval_after_place: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> $past(cmd.place))
		else $error("sprite evaluated without a placed sprite entry");

endmodule
`default_nettype wire

// ===== rtl/core/sprite_list_row_generator.sv =====
// Sprite list row generator: places sprites and emits their visible tile rows.
// A frame start, a tile row load or an unused command is handled as it is accepted.
// A sprite entry is accepted, then evaluated; a drawn sprite then gets a scan step for each
// of its sixteen rows plus a fetch step for each emitted row, which waits while the output
// register is occupied. No new input word is accepted until the sprite is done.
// At the earliest, the first result follows the evaluate, scan and fetch steps.
// Reset clears the running position, controller, output valid and the registers to
// their reset values; the tile row store is not cleared and holds nothing until loaded.
`default_nettype none
module sprite_list_row_generator import slrg_pkg::*; #(
	parameter int unsigned TILE_COUNT = TILE_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// colour_word, x_byte, y_byte, code_low, attr_word, load_index, load_pixels
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	// cmd
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// screen_row, start_x, pixels, write_mask, palette_bank, zero fill
	output logic      [M_DATA_W-1:0]   m_tdata,
	// last_row
	output logic                       m_tlast
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	slrg_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	slrg_datapath #(
		.TILE_COUNT (TILE_COUNT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== bench/sprite_list_row_generator_tb.sv =====
// Self-checking sprite list row generator bench: directed and random traffic against a row predictor.
`default_nettype none
module sprite_list_row_generator_tb;
	import slrg_pkg::*;

	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         DRAIN_CYCLES = 40;
	localparam int         LONG_STALL   = 400;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] colour;
		logic [7:0]  x_byte;
		logic [7:0]  y_byte;
		logic [7:0]  code_low;
		logic [15:0] attr;
		logic [15:0] load_index;
		logic [63:0] load_pixels;
	} list_word_t;

	typedef struct packed {
		logic [8:0]  screen_row;
		logic [8:0]  start_x;
		logic [63:0] pixels;
		logic [15:0] write_mask;
		logic [3:0]  palette_bank;
		logic        last_row;
	} row_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	wire  [31:0]           prdata;
	wire                   pready;
	logic                  s_tvalid = 1'b0;
	wire                   s_tready;
	// colour_word, x_byte, y_byte, code_low, attr_word, load_index, load_pixels
	logic [S_DATA_W-1:0]   s_tdata = '0;
	// cmd
	logic [1:0]            s_tuser = '0;
	wire                   m_tvalid;
	logic                  m_tready = 1'b0;
	// screen_row, start_x, pixels, write_mask, palette_bank, zero fill
	wire  [M_DATA_W-1:0]   m_tdata;
	// last_row
	wire                   m_tlast;

	list_word_t  list_queue[$];
	list_word_t  on_bus;
	row_word_t   rows_due[$];
	row_word_t   seen;
	row_word_t   want;
	logic [63:0] tile_mem [int];
	int          tiles_ready[$];
	cfg_t        cfg_now;
	int          run_x = 0;
	int          run_y = 0;
	int          mismatches = 0;
	bit          idle_on = 1'b1;
	int          tx_gap = 0;
	int          rx_gap = 0;
	int          stall_left = 0;
	logic        stall_request = 1'b0;

	sprite_list_row_generator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sign, optional relative step with 18-bit wrap, then fold anything above 511.
	function automatic int place_coord(int run, logic [7:0] raw, logic neg, logic rel);
		int         s;
		int         v;
		logic [17:0] sum;
		s = int'(raw);
		if (neg)
			s -= 256;
		if (rel) begin
			sum = 18'(run + s);
			v = int'($signed(sum));
		end else begin
			v = s;
		end
		if (v > 511)
			v = v & 511;
		return v;
	endfunction

	function automatic void apply_list_word(list_word_t w);
		row_word_t   fresh[$];
		row_word_t   r_out;
		logic [11:0] tile;
		logic [63:0] src;
		logic [3:0]  p;
		int          x, y, py, col, top, bottom;
		top = int'(cfg_now.window_top);
		bottom = int'(cfg_now.window_bottom);
		case (w.cmd)
			CMD_FRAME: begin
				run_x = 0;
				run_y = 0;
			end
			CMD_LOAD: tile_mem[int'(w.load_index)] = w.load_pixels;
			CMD_SPRITE: begin
				x = place_coord(run_x, w.x_byte, w.colour[0], w.colour[2]);
				y = place_coord(run_y, w.y_byte, w.colour[1], w.colour[2]);
				run_x = x;
				run_y = y;
				tile = {w.attr[3:0], w.code_low};
				if (x > -16 && x < 256 && y > 0 && y < 240 && tile < TILE_COUNT_DEF) begin
					for (int r = 0; r < 16; r++) begin
						// Vertical flip moves the row on screen but not its place in the output order.
						py = y + (w.attr[7] ? 15 - r : r);
						if (py >= top && py <= bottom) begin
							src = tile_mem[int'({tile, 4'(r)})];
							r_out = '0;
							for (int k = 0; k < 16; k++) begin
								col = w.attr[6] ? 15 - k : k;
								p = src[4*col +: 4];
								r_out.pixels[4*k +: 4] = p;
								if (p != cfg_now.clear_pen && x + k >= 0 && x + k < SCREEN_WIDTH)
									r_out.write_mask[k] = 1'b1;
							end
							r_out.screen_row = 9'(py - top);
							r_out.start_x = 9'(x);
							r_out.palette_bank = w.colour[7:4];
							fresh.push_back(r_out);
						end
					end
					foreach (fresh[i]) begin
						r_out = fresh[i];
						r_out.last_row = (i == fresh.size() - 1);
						rows_due.push_back(r_out);
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic list_word_t mk_plain(logic [1:0] cmd);
		list_word_t w;
		w.cmd = cmd;
		w.colour = 16'($urandom);
		w.x_byte = 8'($urandom);
		w.y_byte = 8'($urandom);
		w.code_low = 8'($urandom);
		w.attr = 16'($urandom);
		w.load_index = 16'($urandom);
		w.load_pixels = {$urandom, $urandom};
		return w;
	endfunction

	function automatic list_word_t mk_load(int tile, int row, logic [63:0] pix);
		list_word_t w;
		w = mk_plain(CMD_LOAD);
		w.load_index = {12'(tile), 4'(row)};
		w.load_pixels = pix;
		return w;
	endfunction

	function automatic list_word_t mk_sprite(logic [15:0] colour, logic [7:0] xb, logic [7:0] yb,
			logic [11:0] tile, logic vflip, logic hflip);
		list_word_t w;
		w = mk_plain(CMD_SPRITE);
		w.colour = colour;
		w.x_byte = xb;
		w.y_byte = yb;
		w.code_low = tile[7:0];
		w.attr = {w.attr[15:8], vflip, hflip, w.attr[5:4], tile[11:8]};
		return w;
	endfunction

	// Mostly sprites on loaded tiles that land on or near the screen, with some noise.
	function automatic list_word_t random_word();
		list_word_t w;
		int         pick;
		int         v;
		int         tile;
		pick = $urandom_range(0, 99);
		tile = tiles_ready[$urandom_range(0, tiles_ready.size() - 1)];
		if (pick < 4)
			return mk_plain(CMD_FRAME);
		if (pick < 10)
			return mk_load(tile, $urandom_range(0, 15), {$urandom, $urandom});
		if (pick < 13)
			return mk_plain(CMD_UNUSED);
		w = mk_sprite(16'($urandom), 8'($urandom), 8'($urandom), 12'(tile),
			1'($urandom), 1'($urandom));
		if (pick < 75) begin
			v = $urandom_range(0, 270) - 15;
			w.x_byte = v[7:0];
			w.colour[0] = (v < 0);
			v = $urandom_range(0, 245) - 3;
			w.y_byte = v[7:0];
			w.colour[1] = (v < 0);
			w.colour[2] = 1'b0;
		end else if (pick < 92) begin
			v = $urandom_range(0, 80) - 40;
			w.x_byte = v[7:0];
			w.colour[0] = (v < 0);
			v = $urandom_range(0, 80) - 40;
			w.y_byte = v[7:0];
			w.colour[1] = (v < 0);
			w.colour[2] = 1'b1;
		end
		return w;
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (exp_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("row word mismatch on %s: expected %h, got %h", name, exp_v, got_v);
		end
	endfunction

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_window(logic [8:0] top, logic [8:0] bottom, logic [3:0] pen);
		apb_write(REG_WINDOW_TOP, 32'(top));
		apb_write(REG_WINDOW_BOTTOM, 32'(bottom));
		apb_write(REG_CLEAR_PEN, 32'(pen));
		cfg_now = '{window_top: top, window_bottom: bottom, clear_pen: pen};
	endtask

	// Sampled at the falling edge so that everything done at the rising edge has settled.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (list_queue.size() != 0 || s_tvalid || rows_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				apply_list_word(on_bus);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (list_queue.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 4) == 0) begin
					tx_gap = $urandom_range(0, 2);
					s_tvalid <= 1'b0;
				end else begin
					on_bus = list_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= on_bus.cmd;
					s_tdata <= {on_bus.load_pixels, on_bus.load_index, on_bus.attr,
						on_bus.code_low, on_bus.y_byte, on_bus.x_byte, on_bus.colour};
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left <= stall_left - 1;
		else if (stall_request)
			stall_left <= LONG_STALL;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.screen_row = m_tdata[8:0];
				seen.start_x = m_tdata[17:9];
				seen.pixels = m_tdata[81:18];
				seen.write_mask = m_tdata[97:82];
				seen.palette_bank = m_tdata[101:98];
				seen.last_row = m_tlast;
				if (rows_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("row word with none pending: screen_row %0d start_x %0d",
							seen.screen_row, $signed(seen.start_x));
				end else begin
					want = rows_due.pop_front();
					check_field("screen_row", 64'(want.screen_row), 64'(seen.screen_row));
					check_field("start_x", 64'(want.start_x), 64'(seen.start_x));
					check_field("pixels", want.pixels, seen.pixels);
					check_field("write_mask", 64'(want.write_mask), 64'(seen.write_mask));
					check_field("palette_bank", 64'(want.palette_bank), 64'(seen.palette_bank));
					check_field("last_row", 64'(want.last_row), 64'(seen.last_row));
				end
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				rx_gap = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		logic [63:0] pix;
		cfg_now = '{window_top: WINDOW_TOP_RST, window_bottom: WINDOW_BOTTOM_RST,
			clear_pen: CLEAR_PEN_RST};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every tile a sprite may use is loaded in full before any sprite refers to it.
		tiles_ready = {0, 'hFFF, 'h0FF, 'hF00};
		repeat (4) tiles_ready.push_back($urandom_range(1, 4094));
		foreach (tiles_ready[i]) begin
			for (int r = 0; r < 16; r++) begin
				if (tiles_ready[i] == 0)
					pix = '0;
				else if (tiles_ready[i] == 'hFFF)
					pix = '1;
				else
					pix = {$urandom, $urandom};
				list_queue.push_back(mk_load(tiles_ready[i], r, pix));
			end
		end

		list_queue.push_back(mk_plain(CMD_FRAME));
		list_queue.push_back(mk_sprite(16'h0000, 8'd0, 8'd1, 12'h0FF, 1'b0, 1'b0));
		list_queue.push_back(mk_sprite(16'h0001, 8'd241, 8'd100, 12'h0FF, 1'b0, 1'b1));
		list_queue.push_back(mk_sprite(16'h0001, 8'd240, 8'd100, 12'h0FF, 1'b0, 1'b0));
		list_queue.push_back(mk_sprite(16'h00F0, 8'd255, 8'd239, 12'hF00, 1'b1, 1'b0));
		list_queue.push_back(mk_sprite(16'h0000, 8'd100, 8'd0, 12'hF00, 1'b0, 1'b0));
		list_queue.push_back(mk_sprite(16'h0000, 8'd100, 8'd240, 12'hF00, 1'b0, 1'b0));
		list_queue.push_back(mk_sprite(16'h0002, 8'd50, 8'd255, 12'h0FF, 1'b0, 1'b0));
		list_queue.push_back(mk_sprite(16'hFFF8, 8'd200, 8'd10, 12'hFFF, 1'b1, 1'b1));
		list_queue.push_back(mk_sprite(16'h0010, 8'd7, 8'd120, 12'h000, 1'b0, 1'b0));
		// Three relative steps to the right carry x past 511, where it folds back.
		list_queue.push_back(mk_sprite(16'h0004, 8'd200, 8'd100, 12'h0FF, 1'b0, 1'b0));
		list_queue.push_back(mk_sprite(16'h0004, 8'd200, 8'd100, 12'h0FF, 1'b0, 1'b1));
		list_queue.push_back(mk_sprite(16'h0004, 8'd200, 8'd100, 12'h0FF, 1'b1, 1'b0));
		list_queue.push_back(mk_sprite(16'h0007, 8'd10, 8'd10, 12'hF00, 1'b0, 1'b0));
		list_queue.push_back(mk_sprite(16'hFFFF, 8'hFF, 8'hFF, 12'hFFF, 1'b1, 1'b1));
		list_queue.push_back(mk_plain(CMD_UNUSED));
		list_queue.push_back(mk_plain(CMD_FRAME));
		list_queue.push_back(mk_sprite(16'h0004, 8'd30, 8'd40, 12'h0FF, 1'b0, 1'b1));
		wait_drained();

		set_window(9'd0, 9'd511, 4'd15);
		repeat (100) list_queue.push_back(random_word());
		wait_drained();

		// Empty window; a run of steps of -256 drives the running position far negative.
		idle_on = 1'b0;
		set_window(9'd511, 9'd0, 4'd0);
		list_queue.push_back(mk_plain(CMD_FRAME));
		repeat (60)
			list_queue.push_back(mk_sprite({13'($urandom), 3'b111}, 8'd0, 8'd0,
				12'(tiles_ready[$urandom_range(0, tiles_ready.size() - 1)]), 1'b0, 1'b0));
		repeat (20) list_queue.push_back(random_word());
		wait_drained();

		// The receiver holds off while the sender keeps offering, so the block backs up.
		idle_on = 1'b1;
		set_window(9'd100, 9'd150, 4'($urandom));
		@(posedge clk);
		stall_request <= 1'b1;
		@(posedge clk);
		stall_request <= 1'b0;
		repeat (100) list_queue.push_back(random_word());
		wait_drained();

		idle_on = 1'b0;
		set_window(9'($urandom_range(0, 60)), 9'($urandom_range(180, 511)), 4'($urandom));
		repeat (60) list_queue.push_back(random_word());
		wait_drained();

		if (mismatches == 0 && rows_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/slrg_pkg.sv
rtl/core/slrg_cfg_regs.sv
rtl/core/slrg_datapath.sv
rtl/core/slrg_ctrl.sv
rtl/core/sprite_list_row_generator.sv
bench/sprite_list_row_generator_tb.sv
